@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/ledcd_pkg.sv @@
// ----------------------------------------------------------------------------
// ledcd_pkg
// action codes, command text and limits for the led command decoder
// ----------------------------------------------------------------------------
package ledcd_pkg;

  typedef logic [4:0]  action_t;
  typedef logic [7:0]  char_t;
  typedef logic [6:0]  pair_t;
  typedef logic [13:0] value_t;

  // action codes
  localparam action_t ACT_UNEXP       = 5'd0;
  localparam action_t ACT_OUT_EN      = 5'd1;
  localparam action_t ACT_OUT_DS      = 5'd2;
  localparam action_t ACT_OUT_TG      = 5'd3;
  localparam action_t ACT_ON_SET      = 5'd4;
  localparam action_t ACT_ON_CLR      = 5'd5;
  localparam action_t ACT_OFF_SET     = 5'd6;
  localparam action_t ACT_OFF_CLR     = 5'd7;
  localparam action_t ACT_ALL_ON_SET  = 5'd8;
  localparam action_t ACT_ALL_ON_CLR  = 5'd9;
  localparam action_t ACT_ALL_OFF_SET = 5'd10;
  localparam action_t ACT_ALL_OFF_CLR = 5'd11;
  localparam action_t ACT_SLEEP_ON    = 5'd12;
  localparam action_t ACT_SLEEP_OFF   = 5'd13;
  localparam action_t ACT_DUTY_ALL    = 5'd14;
  localparam action_t ACT_DUTY_ONE    = 5'd15;
  localparam action_t ACT_LED_RANGE   = 5'd16;
  localparam action_t ACT_FREQ        = 5'd17;
  localparam action_t ACT_FREQ_RANGE  = 5'd18;

  // group selector characters and decimal digit bounds
  localparam char_t CH_O = "O";
  localparam char_t CH_A = "A";
  localparam char_t CH_S = "S";
  localparam char_t CH_D = "D";
  localparam char_t CH_F = "F";
  localparam char_t CH_ZERO = "0";
  localparam char_t CH_NINE = "9";

  // full five-character commands
  localparam logic [39:0] TXT_OUT_EN      = "OutEn";
  localparam logic [39:0] TXT_OUT_DS      = "OutDs";
  localparam logic [39:0] TXT_OUT_TG      = "OutTg";
  localparam logic [39:0] TXT_ALL_ON_SET  = "AllON";
  localparam logic [39:0] TXT_ALL_ON_CLR  = "AlnON";
  localparam logic [39:0] TXT_ALL_OFF_SET = "AlOFF";
  localparam logic [39:0] TXT_ALL_OFF_CLR = "AnOFF";
  localparam logic [39:0] TXT_SLEEP_ON    = "SlmEn";
  localparam logic [39:0] TXT_SLEEP_OFF   = "SlmDs";

  // three-character prefixes followed by two digits
  localparam logic [23:0] PRE_ON_CLR   = "ONn";
  localparam logic [23:0] PRE_ON_SET   = "ON-";
  localparam logic [23:0] PRE_OFF_SET  = "OFF";
  localparam logic [23:0] PRE_OFF_CLR  = "OFn";
  localparam logic [23:0] PRE_DUTY_ALL = "DAl";

  // frequency limits in hertz
  localparam value_t FREQ_MIN = 14'd24;
  localparam value_t FREQ_MAX = 14'd1526;

  // ascii decimal digit test
  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // two ascii digits to a number 0..99
  function automatic pair_t dig_pair(input char_t tens, input char_t units);
    return 7'(tens[3:0]) * 7'd10 + 7'(units[3:0]);
  endfunction

endpackage

@@ rtl/led_command_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// led_command_decoder_unit
// decodes one five-character ascii command into one led pwm controller action
// ----------------------------------------------------------------------------
// usage:
//   a command is taken on the rising edge where start is high and busy is low;
//   cmd_byte_0..cmd_byte_4 carry the five characters in order.
//   busy is low whenever rst is low, so a new command may follow every cycle.
//   each command yields exactly one result: done is high for one cycle with
//   action, led_index and value, and the result transfer completes at the end
//   of that cycle. the receiver has no way to hold results off.
// pipeline:
//   a command passes the input register, then is decoded into the result
//   register, which drives done, action, led_index and value; one command
//   per cycle sustained while rst is low, set by the single decode stage
//   between the two registers.
// reset:
//   synchronous rst clears the pipeline valid flags; busy is high while rst
//   is high, and commands in flight at reset are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_command_decoder_unit
  import ledcd_pkg::*;
#(
  parameter int MAX_LED_INDEX = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  cmd_byte_0,
  input  logic [7:0]  cmd_byte_1,
  input  logic [7:0]  cmd_byte_2,
  input  logic [7:0]  cmd_byte_3,
  input  logic [7:0]  cmd_byte_4,
  output logic        done,
  output logic [4:0]  action,
  output logic [6:0]  led_index,
  output logic [13:0] value
);

  localparam pair_t LED_LIMIT = 7'(MAX_LED_INDEX);

  logic   in_valid;
  char_t  b0, b1, b2, b3, b4;

  action_t action_next;
  pair_t   led_index_next;
  value_t  value_next;

  logic [39:0] txt5;
  logic [23:0] txt3;
  logic        dig1, dig2, dig3, dig4;
  pair_t       pair_hi, pair_lo;
  value_t      freq;

  assign busy = rst;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      b0 <= cmd_byte_0;
      b1 <= cmd_byte_1;
      b2 <= cmd_byte_2;
      b3 <= cmd_byte_3;
      b4 <= cmd_byte_4;
    end
  end

  // digit tests and decimal conversion
  assign txt5    = {b0, b1, b2, b3, b4};
  assign txt3    = {b0, b1, b2};
  assign dig1    = is_digit(b1);
  assign dig2    = is_digit(b2);
  assign dig3    = is_digit(b3);
  assign dig4    = is_digit(b4);
  assign pair_hi = dig_pair(b1, b2);
  assign pair_lo = dig_pair(b3, b4);
  assign freq    = 14'(b1[3:0]) * 14'd1000 + 14'(b2[3:0]) * 14'd100 + 14'(pair_lo);

  // command decode
  always_comb begin
    action_next    = ACT_UNEXP;
    led_index_next = '0;
    value_next     = '0;
    case (b0)
      CH_O: begin
        if (txt5 == TXT_OUT_EN) begin
          action_next = ACT_OUT_EN;
        end else if (txt5 == TXT_OUT_DS) begin
          action_next = ACT_OUT_DS;
        end else if (txt5 == TXT_OUT_TG) begin
          action_next = ACT_OUT_TG;
        end else if (dig3 && dig4) begin
          led_index_next = pair_lo;
          if (txt3 == PRE_ON_CLR) begin
            action_next = ACT_ON_CLR;
          end else if (txt3 == PRE_ON_SET) begin
            action_next = ACT_ON_SET;
          end else if (txt3 == PRE_OFF_SET) begin
            action_next = ACT_OFF_SET;
          end else if (txt3 == PRE_OFF_CLR) begin
            action_next = ACT_OFF_CLR;
          end else begin
            led_index_next = '0;
          end
        end
      end
      CH_A: begin
        if (txt5 == TXT_ALL_ON_SET) begin
          action_next = ACT_ALL_ON_SET;
        end else if (txt5 == TXT_ALL_ON_CLR) begin
          action_next = ACT_ALL_ON_CLR;
        end else if (txt5 == TXT_ALL_OFF_SET) begin
          action_next = ACT_ALL_OFF_SET;
        end else if (txt5 == TXT_ALL_OFF_CLR) begin
          action_next = ACT_ALL_OFF_CLR;
        end
      end
      CH_S: begin
        if (txt5 == TXT_SLEEP_ON) begin
          action_next = ACT_SLEEP_ON;
        end else if (txt5 == TXT_SLEEP_OFF) begin
          action_next = ACT_SLEEP_OFF;
        end
      end
      CH_D: begin
        if (txt3 == PRE_DUTY_ALL) begin
          if (dig3 && dig4) begin
            action_next = ACT_DUTY_ALL;
            value_next  = 14'(pair_lo);
          end
        end else if (dig1 && dig2 && dig3 && dig4) begin
          led_index_next = pair_hi;
          if (pair_hi <= LED_LIMIT) begin
            action_next = ACT_DUTY_ONE;
            value_next  = 14'(pair_lo);
          end else begin
            action_next = ACT_LED_RANGE;
          end
        end
      end
      CH_F: begin
        if (dig1 && dig2 && dig3 && dig4) begin
          value_next  = freq;
          action_next = (freq >= FREQ_MIN && freq <= FREQ_MAX) ? ACT_FREQ : ACT_FREQ_RANGE;
        end
      end
      default: begin
        action_next = ACT_UNEXP;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    action    <= action_next;
    led_index <= led_index_next;
    value     <= value_next;
  end

  // every accepted command gives a result through the input and result registers
  `ASSERT_NEXT(a_result_latency, clk, rst, start && !busy, ##1 done)
  // action codes stay within the defined set
  `ASSERT_IMPLY(a_action_range, clk, rst, done, action <= ACT_FREQ_RANGE)
  // per-led duty never carries an led number above the limit
  `ASSERT_IMPLY(a_duty_led_limit, clk, rst, done && action == ACT_DUTY_ONE,
                led_index <= LED_LIMIT)
  // led index is zero unless the action names one led
  `ASSERT_IMPLY(a_led_zero, clk, rst, done && !(action == ACT_ON_SET ||
                action == ACT_ON_CLR || action == ACT_OFF_SET || action == ACT_OFF_CLR ||
                action == ACT_DUTY_ONE || action == ACT_LED_RANGE), led_index == '0)
  // value is zero unless the action carries duty or frequency
  `ASSERT_IMPLY(a_value_zero, clk, rst, done && !(action == ACT_DUTY_ALL ||
                action == ACT_DUTY_ONE || action == ACT_FREQ || action == ACT_FREQ_RANGE),
                value == '0)

endmodule
